>>> rtl/tfsd_pkg.sv
// Shared types, constants and the coefficient table of the three-axis FIR block.
package tfsd_pkg;

  // Fixed field widths
  localparam int SMP_W  = 16;
  localparam int COEF_W = 18;
  localparam int PROD_W = SMP_W + COEF_W;
  localparam int ACC_W  = 44;
  localparam int COEF_SHIFT = 22;
  localparam int NUM_FIELDS = 3;
  localparam int AX_W   = 2;
  localparam int HALF_COEFS = 159;
  localparam int FULL_COEFS = 318;
  localparam int CIDX_W = 10;

  // Configuration register indexes
  localparam logic [1:0] REG_SPIKE_LIMIT = 2'd0;
  localparam logic [1:0] REG_DEAD_BAND   = 2'd1;
  localparam logic [1:0] REG_Z_OFFSET    = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SPIKE,
    ST_BAND,
    ST_DONE
  } state_e;

  // Control from the sequencer to the MAC
  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  // First half of the symmetric low-pass table, units of 2^-22
  localparam int HALF_COEF [HALF_COEFS] = '{
    -382, -189, -235, -286, -343, -407, -476, -553, -636, -725,
    -821, -922, -1030, -1142, -1260, -1382, -1506, -1634, -1763, -1893,
    -2021, -2148, -2271, -2390, -2501, -2605, -2698, -2780, -2848, -2901,
    -2936, -2953, -2947, -2919, -2867, -2787, -2680, -2544, -2377, -2178,
    -1946, -1681, -1381, -1048, -681, -280, 154, 620, 1117, 1642,
    2195, 2772, 3372, 3990, 4623, 5269, 5922, 6578, 7233, 7881,
    8518, 9139, 9737, 10308, 10845, 11343, 11796, 12199, 12545, 12831,
    13050, 13197, 13269, 13260, 13168, 12989, 12720, 12359, 11905, 11356,
    10713, 9977, 9148, 8230, 7224, 6135, 4968, 3728, 2422, 1056,
    -361, -1820, -3312, -4827, -6354, -7881, -9396, -10887, -12340, -13744,
    -15083, -16346, -17517, -18583, -19531, -20348, -21020, -21536, -21883, -22050,
    -22026, -21803, -21370, -20721, -19849, -18748, -17414, -15844, -14036, -11991,
    -9710, -7195, -4451, -1484, 1700, 5091, 8680, 12454, 16402, 20507,
    24756, 29131, 33614, 38187, 42830, 47522, 52243, 56971, 61684, 66359,
    70974, 75506, 79933, 84234, 88386, 92368, 96160, 99743, 103098, 106207,
    109055, 111625, 113905, 115882, 117547, 118889, 119902, 120580, 120920
  };

  // Coefficient of tap j: mirrored table, zero past the table's end
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [CIDX_W-1:0] j);
    logic [CIDX_W-1:0] m;
    m = CIDX_W'(FULL_COEFS - 1) - j;
    if (j < CIDX_W'(HALF_COEFS)) begin
      return COEF_W'(HALF_COEF[j[7:0]]);
    end else if (j < CIDX_W'(FULL_COEFS)) begin
      return COEF_W'(HALF_COEF[m[7:0]]);
    end else begin
      return '0;
    end
  endfunction

  // Saturate a 17-bit signed value to 16 bits
  function automatic logic signed [SMP_W-1:0] sat17(input logic signed [SMP_W:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[SMP_W-1:0];
    end
  endfunction

endpackage

>>> rtl/tfsd_ram.sv
// Generic simple dual-port RAM with registered read.
module tfsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 954
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tfsd_mac.sv
// Shared multiply-accumulate unit: registered product, then exact accumulation.
module tfsd_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tfsd_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [tfsd_pkg::COEF_W-1:0]    coef_i,
  input  logic signed [tfsd_pkg::SMP_W-1:0]     sample_i,
  output logic signed [tfsd_pkg::ACC_W-1:0]     acc_o
);

  logic                                 pv_q;
  logic signed [tfsd_pkg::PROD_W-1:0]   prod_q;
  logic signed [tfsd_pkg::ACC_W-1:0]    acc_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * sample_i;
  end

  // Product valid and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= ctrl_i.en;
      if (pv_q) begin
        acc_q <= acc_q + tfsd_pkg::ACC_W'(prod_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/three_axis_fir_spike_deadband.sv
// Top level: three-axis FIR low-pass with spike rejection, z offset and deadband.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, accel_{x,y,z}_i   | sink
//  out      | out_valid_o, out_ready_i, filtered_{x,y,z}_o | source
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | sink
//
// A filling beat is accepted, then written to the window RAM once per axis.
// In a filtering beat the single MAC and the single read port of the window RAM
// visit each tap once per axis.
// in_ready_o is high only while the sequencer is idle; a finished result waits in
// the output register and only stalls the block if the next result is ready first.
// Reset clears control state and previous outputs and presets the configuration;
// the window RAM is not cleared, as the first TAPS beats write every entry before any read.
module three_axis_fir_spike_deadband #(
  parameter int TAPS = 318,
  parameter int AXES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] filtered_x_o,
  output logic signed [15:0] filtered_y_o,
  output logic signed [15:0] filtered_z_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int DEPTH = AXES * TAPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(TAPS);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int SW    = tfsd_pkg::SMP_W;

  tfsd_pkg::state_e state_q, state_d;

  logic [FW-1:0]   fill_q;
  logic [IW-1:0]   wptr_q;
  logic [IW-1:0]   slot_q;
  logic [IW-1:0]   idx_q;
  logic [IW-1:0]   j_q;
  logic [AW-1:0]   base_q;
  logic [tfsd_pkg::AX_W-1:0] ax_q;
  logic            drn_q;
  logic            v1_q;
  logic            out_valid_q;

  logic [15:0]     spike_q;
  logic [14:0]     band_q;
  logic signed [SW-1:0] zoff_q;

  logic signed [SW-1:0] smp_q  [tfsd_pkg::NUM_FIELDS];
  logic signed [SW-1:0] prev_q [tfsd_pkg::NUM_FIELDS];
  logic signed [SW-1:0] res_q  [tfsd_pkg::NUM_FIELDS];
  logic signed [SW-1:0] out_q  [tfsd_pkg::NUM_FIELDS];
  logic signed [SW-1:0] y_q;
  logic signed [tfsd_pkg::COEF_W-1:0] coef_q;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [SW-1:0]   ram_rdata;
  logic signed [tfsd_pkg::ACC_W-1:0] acc;
  tfsd_pkg::mac_ctrl_t mac_ctrl;

  logic            last_ax;
  logic            start_ax;
  logic            out_free;

  // Rounding, spike and deadband arithmetic
  logic signed [tfsd_pkg::ACC_W-1:0] acc_rnd;
  logic signed [tfsd_pkg::ACC_W-tfsd_pkg::COEF_SHIFT-1:0] acc_sh;
  logic signed [SW-1:0] y_round;
  logic signed [SW:0]   diff;
  logic [SW:0]          diff_abs;
  logic signed [SW-1:0] y_spk;
  logic signed [SW-1:0] y_off;
  logic [SW:0]          y_abs;
  logic signed [SW-1:0] y_band;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == tfsd_pkg::ST_IDLE);
  assign last_ax     = (ax_q == tfsd_pkg::AX_W'(AXES - 1));
  assign out_free    = !out_valid_q || out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_q <= 16'd800;
      band_q  <= 15'd100;
      zoff_q  <= 16'sd80;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tfsd_pkg::REG_SPIKE_LIMIT: spike_q <= cfg_data_i;
        tfsd_pkg::REG_DEAD_BAND:   band_q  <= cfg_data_i[14:0];
        tfsd_pkg::REG_Z_OFFSET:    zoff_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control
  always_comb begin
    state_d  = state_q;
    start_ax = 1'b0;
    case (state_q)
      tfsd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tfsd_pkg::ST_WRITE;
        end
      end
      tfsd_pkg::ST_WRITE: begin
        if (last_ax) begin
          if (fill_q < FW'(TAPS)) begin
            state_d = tfsd_pkg::ST_IDLE;
          end else begin
            state_d  = tfsd_pkg::ST_MAC;
            start_ax = 1'b1;
          end
        end
      end
      tfsd_pkg::ST_MAC: begin
        if (j_q == IW'(TAPS - 1)) begin
          state_d = tfsd_pkg::ST_DRAIN;
        end
      end
      tfsd_pkg::ST_DRAIN: begin
        if (drn_q) begin
          state_d = tfsd_pkg::ST_ROUND;
        end
      end
      tfsd_pkg::ST_ROUND: state_d = tfsd_pkg::ST_SPIKE;
      tfsd_pkg::ST_SPIKE: state_d = tfsd_pkg::ST_BAND;
      tfsd_pkg::ST_BAND: begin
        if (last_ax) begin
          state_d = tfsd_pkg::ST_DONE;
        end else begin
          state_d  = tfsd_pkg::ST_MAC;
          start_ax = 1'b1;
        end
      end
      tfsd_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tfsd_pkg::ST_IDLE;
        end
      end
      default: state_d = tfsd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer counters and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      wptr_q <= '0;
      slot_q <= '0;
      idx_q  <= '0;
      j_q    <= '0;
      base_q <= '0;
      ax_q   <= '0;
      drn_q  <= 1'b0;
      v1_q   <= 1'b0;
    end else begin
      v1_q <= (state_q == tfsd_pkg::ST_MAC);
      case (state_q)
        tfsd_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            slot_q <= wptr_q;
            ax_q   <= '0;
            base_q <= '0;
          end
        end
        tfsd_pkg::ST_WRITE: begin
          if (last_ax) begin
            wptr_q <= (wptr_q == IW'(TAPS - 1)) ? '0 : wptr_q + 1'b1;
            if (fill_q < FW'(TAPS)) begin
              fill_q <= fill_q + 1'b1;
            end
            ax_q   <= '0;
            base_q <= '0;
          end else begin
            ax_q   <= ax_q + 1'b1;
            base_q <= base_q + AW'(TAPS);
          end
          idx_q <= slot_q;
          j_q   <= '0;
        end
        tfsd_pkg::ST_MAC: begin
          j_q   <= j_q + 1'b1;
          idx_q <= (idx_q == '0) ? IW'(TAPS - 1) : idx_q - 1'b1;
          drn_q <= 1'b0;
        end
        tfsd_pkg::ST_DRAIN: drn_q <= 1'b1;
        tfsd_pkg::ST_BAND: begin
          if (!last_ax) begin
            ax_q   <= ax_q + 1'b1;
            base_q <= base_q + AW'(TAPS);
            idx_q  <= slot_q;
            j_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample latch and coefficient stage
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q[0] <= accel_x_i;
      smp_q[1] <= accel_y_i;
      smp_q[2] <= accel_z_i;
    end
    coef_q <= tfsd_pkg::coef_at(tfsd_pkg::CIDX_W'(j_q));
  end

  // Window RAM access
  assign ram_we    = (state_q == tfsd_pkg::ST_WRITE);
  assign ram_waddr = base_q + AW'(slot_q);
  assign ram_re    = (state_q == tfsd_pkg::ST_MAC);
  assign ram_raddr = base_q + AW'(idx_q);

  tfsd_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (smp_q[ax_q]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign mac_ctrl.clear = start_ax;
  assign mac_ctrl.en    = v1_q;

  tfsd_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_q),
    .sample_i (ram_rdata),
    .acc_o    (acc)
  );

  // Round half up, then saturate
  always_comb begin
    acc_rnd = acc + (tfsd_pkg::ACC_W'(1) <<< (tfsd_pkg::COEF_SHIFT - 1));
    acc_sh  = acc_rnd[tfsd_pkg::ACC_W-1:tfsd_pkg::COEF_SHIFT];
    if (acc_sh > 22'sd32767) begin
      y_round = 16'sh7fff;
    end else if (acc_sh < -22'sd32768) begin
      y_round = 16'sh8000;
    end else begin
      y_round = acc_sh[SW-1:0];
    end
  end

  // Spike hold and z offset
  always_comb begin
    diff     = {y_q[SW-1], y_q} - {prev_q[ax_q][SW-1], prev_q[ax_q]};
    diff_abs = diff[SW] ? (SW+1)'(-diff) : diff;
    y_spk    = (diff_abs > {1'b0, spike_q}) ? prev_q[ax_q] : y_q;
    y_off    = tfsd_pkg::sat17({y_spk[SW-1], y_spk} - {zoff_q[SW-1], zoff_q});
  end

  // Deadband
  always_comb begin
    y_abs  = y_q[SW-1] ? (SW+1)'(-{y_q[SW-1], y_q}) : {1'b0, y_q};
    y_band = (y_abs < {2'b00, band_q}) ? '0 : y_q;
  end

  // Per-axis result path
  always_ff @(posedge clk_i) begin
    case (state_q)
      tfsd_pkg::ST_ROUND: y_q <= y_round;
      tfsd_pkg::ST_SPIKE: y_q <= (ax_q == 2'd2) ? y_off : y_spk;
      tfsd_pkg::ST_BAND:  res_q[ax_q] <= y_band;
      default: ;
    endcase
  end

  // Previous outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      prev_q[2] <= '0;
    end else if (state_q == tfsd_pkg::ST_BAND) begin
      prev_q[ax_q] <= y_band;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == tfsd_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tfsd_pkg::ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_x_o = out_q[0];
  assign filtered_y_o = (AXES > 1) ? out_q[1] : '0;
  assign filtered_z_o = (AXES > 2) ? out_q[2] : '0;

endmodule

>>> sim/three_axis_fir_spike_deadband_test.sv
// Self-checking testbench of the three-axis FIR low-pass with spike hold, z offset and deadband.
module three_axis_fir_spike_deadband_test;

  localparam int TAPS = 318;
  localparam int AXES = 3;
  // Longest filtering beat plus margin; also the settling pause before register writes
  localparam int BUSY_CYCLES = 2 + AXES + AXES * (TAPS + 5) + 64;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int PRINT_LIMIT = 40;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_BEATS = 50;
  // Index with no register behind it; writes to it must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } triple_t;

  typedef enum int {SIG_DRIFT, SIG_STEPS, SIG_NOISE} sig_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [15:0] accel_x_i;
  logic signed [15:0] accel_y_i;
  logic signed [15:0] accel_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [15:0] filtered_x_o;
  logic signed [15:0] filtered_y_o;
  logic signed [15:0] filtered_z_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predictor state: sample window, held outputs and register copies
  logic signed [15:0] win_q [AXES][TAPS];
  int unsigned win_wr = 0;
  int unsigned win_fill = 0;
  int last_out [3] = '{0, 0, 0};
  int spike_lim = 800;
  int band_lim = 100;
  int z_off = 80;
  triple_t filtered_q [$];

  // Bookkeeping
  int walk [3] = '{0, 0, 0};
  bit steady_mode = 1'b0;
  int sink_hold = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int writes_done = 0;
  triple_t got_r;
  triple_t want_r;

  three_axis_fir_spike_deadband i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_x_o (filtered_x_o),
    .filtered_y_o (filtered_y_o),
    .filtered_z_o (filtered_z_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, filtered_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Idle length for either side: mostly none, some short, a few long
  function automatic int stall_len();
    int r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Next sample of a per-axis signal; one in ten is a full-range outlier (every sample for noise)
  function automatic triple_t next_signal(input sig_kind_e kind);
    int a;
    int v;
    logic signed [15:0] f [3];
    for (a = 0; a < 3; a++) begin
      if ($urandom_range(0, 9) == 0 || kind == SIG_NOISE) begin
        v = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        if (kind == SIG_DRIFT) begin
          v = clamp16(walk[a] + int'($urandom_range(0, 1200)) - 600);
        end else if ($urandom_range(0, 4) == 0) begin
          v = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          v = walk[a];
        end
        walk[a] = v;
      end
      f[a] = v[15:0];
    end
    return '{x: f[0], y: f[1], z: f[2]};
  endfunction

  // Filter, spike hold, z offset and deadband for one accepted beat
  function automatic void predict_sample(input triple_t s);
    int unsigned slot;
    int unsigned idx;
    int a;
    int j;
    int c;
    int y;
    int d;
    longint acc;
    logic signed [15:0] raw [3];
    logic signed [15:0] res [3];
    raw[0] = s.x;
    raw[1] = s.y;
    raw[2] = s.z;
    slot = win_wr;
    for (a = 0; a < AXES; a++) win_q[a][slot] = raw[a];
    win_wr = (slot + 1 >= TAPS) ? 0 : slot + 1;
    // window still filling: no result
    if (win_fill < TAPS) begin
      win_fill++;
      return;
    end
    for (a = 0; a < 3; a++) begin
      acc = 0;
      idx = slot;
      for (j = 0; j < TAPS; j++) begin
        if (j < tfsd_pkg::HALF_COEFS) c = tfsd_pkg::HALF_COEF[j];
        else if (j < tfsd_pkg::FULL_COEFS) c = tfsd_pkg::HALF_COEF[tfsd_pkg::FULL_COEFS - 1 - j];
        else c = 0;
        acc += longint'(c) * longint'(win_q[a][idx]);
        idx = (idx == 0) ? TAPS - 1 : idx - 1;
      end
      // round half up, then saturate
      y = clamp16((acc + (longint'(1) << (tfsd_pkg::COEF_SHIFT - 1))) >>> tfsd_pkg::COEF_SHIFT);
      d = y - last_out[a];
      if (d < 0) d = -d;
      if (d > spike_lim) y = last_out[a];
      if (a == 2) y = clamp16(longint'(y) - longint'(z_off));
      if ((y < 0 ? -y : y) < band_lim) y = 0;
      last_out[a] = y;
      res[a] = y[15:0];
    end
    filtered_q.push_back('{x: res[0], y: res[1], z: res[2]});
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch at cycle %0d, result %0d: %s got %0d expected %0d",
               cycle_count, results_seen, what, got, want);
    end
  endtask

  // One input beat: optional gap, then hold valid until accepted
  task automatic send_sample(input triple_t s);
    int gap;
    gap = stall_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    accel_x_i = s.x;
    accel_y_i = s.y;
    accel_z_i = s.z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_sample(s);
    beats_sent++;
  endtask

  // Let every expected result out, then give a filling beat time to finish
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (BUSY_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      tfsd_pkg::REG_SPIKE_LIMIT: spike_lim = int'(data);
      tfsd_pkg::REG_DEAD_BAND:   band_lim = int'(data[14:0]);
      tfsd_pkg::REG_Z_OFFSET:    z_off = int'($signed(data));
      default: ;
    endcase
    writes_done++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] spike, input logic [15:0] band,
                                input logic [15:0] zoff);
    settle_block();
    write_register(tfsd_pkg::REG_SPIKE_LIMIT, spike);
    write_register(tfsd_pkg::REG_DEAD_BAND, band);
    write_register(tfsd_pkg::REG_Z_OFFSET, zoff);
  endtask

  // Result sink with random stalls; now and then a very long one to back the block up
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
      if (!steady_mode && out_valid_o && $urandom_range(0, 11) == 0) begin
        sink_hold = $urandom_range(1000, 2500);
      end else begin
        sink_hold = stall_len();
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_r = '{x: filtered_x_o, y: filtered_y_o, z: filtered_z_o};
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected result, x", int'(got_r.x), 0);
      end else begin
        want_r = filtered_q.pop_front();
        if (got_r.x !== want_r.x) report_mismatch("filtered_x", int'(got_r.x), int'(want_r.x));
        if (got_r.y !== want_r.y) report_mismatch("filtered_y", int'(got_r.y), int'(want_r.y));
        if (got_r.z !== want_r.z) report_mismatch("filtered_z", int'(got_r.z), int'(want_r.z));
      end
      results_seen++;
    end
  end

  // Fill phase at reset settings: no beat may produce a result
  task automatic test_window_fill();
    int i;
    for (i = 0; i < TAPS; i++) send_sample(next_signal(SIG_DRIFT));
  endtask

  // First results use the register values left by reset
  task automatic test_reset_settings();
    int i;
    for (i = 0; i < 3; i++) send_sample(next_signal(SIG_DRIFT));
  endtask

  // Full-scale and alternating bit patterns, z offset at both extremes
  task automatic test_field_extremes();
    int i;
    apply_settings(16'hFFFF, 16'h0000, 16'h8000);
    steady_mode = 1'b1;
    for (i = 0; i < 3; i++) send_sample('{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh7FFF});
    for (i = 0; i < 2; i++) send_sample('{x: 16'sh8000, y: 16'sh7FFF, z: 16'sh8000});
    send_sample('{x: 16'sh0000, y: 16'sh0000, z: 16'sh0000});
    send_sample('{x: 16'sh5555, y: 16'shAAAA, z: 16'sh5555});
    send_sample('{x: 16'shAAAA, y: 16'sh5555, z: 16'shAAAA});
    steady_mode = 1'b0;
    settle_block();
    write_register(tfsd_pkg::REG_Z_OFFSET, 16'h7FFF);
    for (i = 0; i < 2; i++) send_sample('{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000});
  endtask

  // Widest deadband via an over-wide write; a write to the spare index is dropped
  task automatic test_dead_band();
    int i;
    settle_block();
    write_register(tfsd_pkg::REG_DEAD_BAND, 16'hFFFF);
    write_register(REG_UNUSED, 16'h0000);
    for (i = 0; i < 3; i++) send_sample('{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh7FFF});
  endtask

  // Zero spike limit: any change holds the previous output
  task automatic test_spike_hold();
    apply_settings(16'h0000, 16'h0000, 16'h0000);
    send_sample('{x: 16'sh1234, y: 16'shEDCB, z: 16'sh0FF0});
    send_sample('{x: 16'sh8000, y: 16'sh7FFF, z: 16'sh8000});
    send_sample('{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh0001});
  endtask

  // Random settings per phase, mostly well-formed signals with outliers
  task automatic test_random_traffic();
    int p;
    int i;
    logic [15:0] spike;
    logic [15:0] band;
    logic [15:0] zoff;
    sig_kind_e kind;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: spike = 16'h0000;
        1: spike = 16'hFFFF;
        2: spike = 16'($urandom_range(0, 4000));
        default: spike = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: band = 16'h0000;
        1: band = 16'h7FFF;
        2: band = 16'($urandom_range(0, 400));
        default: band = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: zoff = 16'h8000;
        1: zoff = 16'h7FFF;
        2: zoff = 16'($urandom_range(0, 1000) - 500);
        default: zoff = 16'($urandom);
      endcase
      apply_settings(spike, band, zoff);
      steady_mode = (p == 1);
      case ($urandom_range(0, 5))
        0: kind = SIG_NOISE;
        1, 2: kind = SIG_STEPS;
        default: kind = SIG_DRIFT;
      endcase
      for (i = 0; i < PHASE_BEATS; i++) send_sample(next_signal(kind));
      steady_mode = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tfsd_pkg::REG_SPIKE_LIMIT;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_window_fill();
    test_reset_settings();
    test_field_extremes();
    test_dead_band();
    test_spike_hold();
    test_random_traffic();

    // drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (BUSY_CYCLES) @(posedge clk_i);
    if (filtered_q.size() != 0) report_mismatch("results never delivered", 0, filtered_q.size());

    $display("covered %0d input beats (%0d window fill), %0d filtered results, %0d reg writes",
             beats_sent, TAPS, results_seen, writes_done);
    $display("spike limit, deadband and z offset taken to both extremes; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
